// ===== rtl/core/drx_pkg.sv =====
// Package with the item types, phase codes and line constants of the DMX512/RDM receiver.
`default_nettype none

package drx_pkg;

    localparam logic [9:0] UNIVERSE_SLOTS   = 10'd512;
    localparam logic [9:0] RDM_BUFFER_BYTES = 10'd512;
    localparam int         UID_BYTES        = 6;

    localparam logic [7:0] START_DMX        = 8'h00;
    localparam logic [7:0] START_RDM        = 8'hCC;
    localparam logic [7:0] SUB_START_RDM    = 8'h01;
    localparam logic [7:0] DISC_PREAMBLE    = 8'hFE;
    localparam logic [7:0] DISC_DELIMITER   = 8'hAA;
    localparam logic [7:0] MIN_GAP_RESET    = 8'd44;
    localparam logic [3:0] DISC_UID_COUNT   = 4'(2 * UID_BYTES);
    localparam logic [3:0] DISC_SUM_COUNT   = 4'd4;

    localparam logic       OP_BYTE          = 1'b0;
    localparam logic       OP_TICK          = 1'b1;
    localparam logic       TARGET_DMX       = 1'b0;
    localparam logic       TARGET_RDM       = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_DMX_DONE  = 2'd1,
        EV_RDM_OK    = 2'd2,
        EV_DISC_OK   = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_BREAK = 4'd1,
        PH_DMX   = 4'd2,
        PH_RDM   = 4'd3,
        PH_SUMH  = 4'd4,
        PH_SUML  = 4'd5,
        PH_DPRE  = 4'd6,
        PH_DUID  = 4'd7,
        PH_DSUM  = 4'd8
    } t_phase;

    typedef struct packed {
        logic        operation;
        logic        line_break;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } t_item;

    typedef struct packed {
        logic        write_enable;
        logic        write_target;
        logic [9:0]  write_index;
        logic [7:0]  write_byte;
        t_event      frame_event;
        logic [9:0]  slot_count;
        logic [31:0] slot_gap_us;
        logic [31:0] break_to_break_us;
        t_phase      receive_phase;
        logic [31:0] dmx_frames_seen;
        logic [31:0] rdm_frames_seen;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/dmx512_rdm_frame_receiver.sv =====
// Top level of the DMX512/RDM frame receiver: stream ports, input and result registers.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = rx_byte, time_us; tuser = operation, line_break
//  m_axis    out        tdata = write/frame fields; tuser = write_enable, target, event
//  cfg       in         i_cfg_we, i_cfg_wdata = min_slot_gap_us
//
// Each item is registered on input, processed by combinational step logic and its
// result is registered on output, so one item per cycle is sustained while results
// are taken on m_axis without a stall. Synchronous active-low reset returns the receiver
// to idle with all counters and times at zero and the minimum slot gap at 44 us.
// A stalled result holds the result register; one further item waits in the input
// register before s_axis_tready falls.
`default_nettype none

module dmx512_rdm_frame_receiver (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // rx_byte [7:0], time_us [39:8]
    input  wire logic [39:0]  s_axis_tdata,
    // operation [0], line_break [1]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // write_index [9:0], write_byte [17:10], slot_count [27:18], slot_gap_us [59:28],
    // break_to_break_us [91:60], receive_phase [95:92], dmx_frames_seen [127:96],
    // rdm_frames_seen [159:128]
    output logic [159:0]      m_axis_tdata,
    // write_enable [0], write_target [1], frame_event [3:2]
    output logic [3:0]        m_axis_tuser
);
    import drx_pkg::*;

    t_item   in_item;
    t_item   core_item;
    logic    core_valid;
    logic    out_can_load;
    logic    advance;
    t_result core_result;
    t_result out_result;

    assign in_item.operation  = s_axis_tuser[0];
    assign in_item.line_break = s_axis_tuser[1];
    assign in_item.rx_byte    = s_axis_tdata[7:0];
    assign in_item.time_us    = s_axis_tdata[39:8];

    assign advance = core_valid && out_can_load;

    drx_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (core_valid),
        .o_item    (core_item)
    );

    drx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_commit    (advance),
        .i_item      (core_item),
        .o_result    (core_result)
    );

    drx_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (core_valid),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {out_result.rdm_frames_seen,
                           out_result.dmx_frames_seen,
                           out_result.receive_phase,
                           out_result.break_to_break_us,
                           out_result.slot_gap_us,
                           out_result.slot_count,
                           out_result.write_byte,
                           out_result.write_index};

    assign m_axis_tuser = {out_result.frame_event,
                           out_result.write_target,
                           out_result.write_enable};

endmodule

`default_nettype wire

// ===== rtl/core/drx_in_stage.sv =====
// Input register that holds one accepted item until the receiver core takes it.
`default_nettype none

module drx_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire drx_pkg::t_item i_item,
    input  wire logic          i_advance,
    output logic               o_valid,
    output drx_pkg::t_item     o_item
);
    import drx_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drx_core.sv =====
// Receiver state and the single-pass step logic that turns one item into one result.
`default_nettype none

module drx_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_wdata,
    input  wire logic           i_commit,
    input  wire drx_pkg::t_item i_item,
    output drx_pkg::t_result    o_result
);
    import drx_pkg::*;

    logic [7:0]  r_min_gap;
    t_phase      r_phase,             n_phase;
    logic [9:0]  r_byte_pos,          n_byte_pos;
    logic [15:0] r_rdm_sum,           n_rdm_sum;
    logic [7:0]  r_rdm_length,        n_rdm_length;
    logic [7:0]  r_rdm_sub_start,     n_rdm_sub_start;
    logic [3:0]  r_disc_count,        n_disc_count;
    logic [31:0] r_last_byte_time,    n_last_byte_time;
    logic [31:0] r_latest_break,      n_latest_break;
    logic [31:0] r_prior_break,       n_prior_break;
    logic        r_prior_was_dmx,     n_prior_was_dmx;
    logic [31:0] r_current_gap,       n_current_gap;
    logic [31:0] r_current_break_gap, n_current_break_gap;
    logic [31:0] r_dmx_count,         n_dmx_count;
    logic [31:0] r_rdm_count,         n_rdm_count;

    logic [31:0] elapsed;
    logic [31:0] min_gap_wide;
    logic [31:0] dmx_gap;
    logic        put_ok;
    logic [9:0]  pos_inc;
    logic [9:0]  dmx_pos;
    logic [7:0]  length_new;
    logic [15:0] sum_low;
    logic [3:0]  disc_inc;
    logic [7:0]  b;

    logic        w_en;
    logic        w_target;
    logic [9:0]  w_index;
    logic [7:0]  w_byte;
    t_event      ev;
    logic [9:0]  slots;

    assign b            = i_item.rx_byte;
    assign elapsed      = i_item.time_us - r_last_byte_time;
    assign min_gap_wide = {24'd0, r_min_gap};
    assign dmx_gap      = (elapsed < min_gap_wide) ? min_gap_wide : elapsed;
    assign put_ok       = r_byte_pos < RDM_BUFFER_BYTES;
    assign pos_inc      = r_byte_pos + 10'd1;
    assign dmx_pos      = (r_byte_pos <= UNIVERSE_SLOTS) ? pos_inc : r_byte_pos;
    assign length_new   = (r_byte_pos == 10'd2) ? b : r_rdm_length;
    assign sum_low      = r_rdm_sum - {8'd0, b};
    assign disc_inc     = r_disc_count + 4'd1;

    always_comb begin
        n_phase             = r_phase;
        n_byte_pos          = r_byte_pos;
        n_rdm_sum           = r_rdm_sum;
        n_rdm_length        = r_rdm_length;
        n_rdm_sub_start     = r_rdm_sub_start;
        n_disc_count        = r_disc_count;
        n_last_byte_time    = r_last_byte_time;
        n_latest_break      = r_latest_break;
        n_prior_break       = r_prior_break;
        n_prior_was_dmx     = r_prior_was_dmx;
        n_current_gap       = r_current_gap;
        n_current_break_gap = r_current_break_gap;
        n_dmx_count         = r_dmx_count;
        n_rdm_count         = r_rdm_count;
        w_en                = 1'b0;
        w_target            = TARGET_DMX;
        w_index             = 10'd0;
        w_byte              = 8'd0;
        ev                  = EV_NONE;
        slots               = 10'd0;

        if (i_item.operation == OP_BYTE) begin
            n_last_byte_time = i_item.time_us;
            if (i_item.line_break) begin
                n_phase        = PH_BREAK;
                n_latest_break = i_item.time_us;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (b == DISC_PREAMBLE) begin
                            n_phase    = PH_DPRE;
                            w_en       = 1'b1;
                            w_target   = TARGET_RDM;
                            w_byte     = DISC_PREAMBLE;
                            n_byte_pos = 10'd1;
                        end
                    end
                    PH_BREAK: begin
                        if (b == START_DMX) begin
                            n_phase             = PH_DMX;
                            w_en                = 1'b1;
                            w_target            = TARGET_DMX;
                            n_byte_pos          = 10'd1;
                            n_dmx_count         = r_dmx_count + 32'd1;
                            n_current_break_gap = r_prior_was_dmx ?
                                                  (r_latest_break - r_prior_break) : 32'd0;
                            n_prior_was_dmx     = 1'b1;
                            n_prior_break       = r_latest_break;
                        end else if (b == START_RDM) begin
                            n_phase         = PH_RDM;
                            w_en            = 1'b1;
                            w_target        = TARGET_RDM;
                            w_byte          = START_RDM;
                            n_rdm_sum       = {8'd0, START_RDM};
                            n_rdm_length    = 8'd0;
                            n_rdm_sub_start = 8'd0;
                            n_byte_pos      = 10'd1;
                            n_rdm_count     = r_rdm_count + 32'd1;
                            n_prior_was_dmx = 1'b0;
                        end else begin
                            n_phase         = PH_IDLE;
                            n_prior_was_dmx = 1'b0;
                        end
                    end
                    PH_DMX: begin
                        n_current_gap = dmx_gap;
                        if (r_byte_pos <= UNIVERSE_SLOTS) begin
                            w_en       = 1'b1;
                            w_target   = TARGET_DMX;
                            w_index    = r_byte_pos;
                            w_byte     = b;
                            n_byte_pos = pos_inc;
                        end
                        if (dmx_pos > UNIVERSE_SLOTS) begin
                            n_phase = PH_IDLE;
                            ev      = EV_DMX_DONE;
                            slots   = UNIVERSE_SLOTS;
                        end
                    end
                    PH_RDM: begin
                        if (r_byte_pos == 10'd1) begin
                            n_rdm_sub_start = b;
                        end
                        n_rdm_length = length_new;
                        if (put_ok) begin
                            w_en       = 1'b1;
                            w_target   = TARGET_RDM;
                            w_index    = r_byte_pos;
                            w_byte     = b;
                            n_byte_pos = pos_inc;
                            n_rdm_sum  = r_rdm_sum + {8'd0, b};
                            if (pos_inc >= 10'd3 && pos_inc == {2'd0, length_new}) begin
                                n_phase = PH_SUMH;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_SUMH: begin
                        if (put_ok) begin
                            w_en       = 1'b1;
                            w_target   = TARGET_RDM;
                            w_index    = r_byte_pos;
                            w_byte     = b;
                            n_byte_pos = pos_inc;
                            n_rdm_sum  = r_rdm_sum - {b, 8'd0};
                            n_phase    = PH_SUML;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_SUML: begin
                        n_phase = PH_IDLE;
                        if (put_ok) begin
                            w_en       = 1'b1;
                            w_target   = TARGET_RDM;
                            w_index    = r_byte_pos;
                            w_byte     = b;
                            n_byte_pos = pos_inc;
                            n_rdm_sum  = sum_low;
                            if (sum_low == 16'd0 && r_rdm_sub_start == SUB_START_RDM) begin
                                ev = EV_RDM_OK;
                            end
                        end
                    end
                    PH_DPRE: begin
                        if (b == DISC_PREAMBLE || b == DISC_DELIMITER) begin
                            if (put_ok) begin
                                w_en       = 1'b1;
                                w_target   = TARGET_RDM;
                                w_index    = r_byte_pos;
                                w_byte     = b;
                                n_byte_pos = pos_inc;
                                if (b == DISC_DELIMITER) begin
                                    n_phase      = PH_DUID;
                                    n_disc_count = 4'd0;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DUID: begin
                        if (put_ok) begin
                            w_en         = 1'b1;
                            w_target     = TARGET_RDM;
                            w_index      = r_byte_pos;
                            w_byte       = b;
                            n_byte_pos   = pos_inc;
                            n_disc_count = disc_inc;
                            if (disc_inc == DISC_UID_COUNT) begin
                                n_phase      = PH_DSUM;
                                n_disc_count = 4'd0;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DSUM: begin
                        if (put_ok) begin
                            w_en         = 1'b1;
                            w_target     = TARGET_RDM;
                            w_index      = r_byte_pos;
                            w_byte       = b;
                            n_byte_pos   = pos_inc;
                            n_disc_count = disc_inc;
                            if (disc_inc == DISC_SUM_COUNT) begin
                                ev      = EV_DISC_OK;
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_phase == PH_DMX && elapsed > r_current_gap) begin
            n_phase = PH_IDLE;
            ev      = EV_DMX_DONE;
            slots   = (r_byte_pos != 10'd0) ? (r_byte_pos - 10'd1) : 10'd0;
        end
    end

    always_comb begin
        o_result.write_enable      = w_en;
        o_result.write_target      = w_target;
        o_result.write_index       = w_index;
        o_result.write_byte        = w_byte;
        o_result.frame_event       = ev;
        o_result.slot_count        = slots;
        o_result.slot_gap_us       = n_current_gap;
        o_result.break_to_break_us = n_current_break_gap;
        o_result.receive_phase     = n_phase;
        o_result.dmx_frames_seen   = n_dmx_count;
        o_result.rdm_frames_seen   = n_rdm_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap           <= MIN_GAP_RESET;
            r_phase             <= PH_IDLE;
            r_byte_pos          <= 10'd0;
            r_rdm_sum           <= 16'd0;
            r_rdm_length        <= 8'd0;
            r_rdm_sub_start     <= 8'd0;
            r_disc_count        <= 4'd0;
            r_last_byte_time    <= 32'd0;
            r_latest_break      <= 32'd0;
            r_prior_break       <= 32'd0;
            r_prior_was_dmx     <= 1'b0;
            r_current_gap       <= 32'd0;
            r_current_break_gap <= 32'd0;
            r_dmx_count         <= 32'd0;
            r_rdm_count         <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                r_min_gap <= i_cfg_wdata;
            end
            if (i_commit) begin
                r_phase             <= n_phase;
                r_byte_pos          <= n_byte_pos;
                r_rdm_sum           <= n_rdm_sum;
                r_rdm_length        <= n_rdm_length;
                r_rdm_sub_start     <= n_rdm_sub_start;
                r_disc_count        <= n_disc_count;
                r_last_byte_time    <= n_last_byte_time;
                r_latest_break      <= n_latest_break;
                r_prior_break       <= n_prior_break;
                r_prior_was_dmx     <= n_prior_was_dmx;
                r_current_gap       <= n_current_gap;
                r_current_break_gap <= n_current_break_gap;
                r_dmx_count         <= n_dmx_count;
                r_rdm_count         <= n_rdm_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drx_out_stage.sv =====
// Result register that holds one result item until the downstream side takes it.
`default_nettype none

module drx_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire drx_pkg::t_result i_result,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output drx_pkg::t_result      o_result
);
    import drx_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
